// ===== hdl/resp_set_members_joiner_assert.svh =====
// assertion macros shared by the joiner rtl files
`ifndef RESP_SET_MEMBERS_JOINER_ASSERT_SVH
`define RESP_SET_MEMBERS_JOINER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define RSMJ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define RSMJ_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

// ===== hdl/rsmj_pkg.sv =====
// types, character codes and sizes for the reply member joiner
`default_nettype none

package rsmj_pkg;

  // ebcdic characters of the reply syntax
  localparam logic [7:0] CH_STAR   = 8'h5C;
  localparam logic [7:0] CH_DOLLAR = 8'h5B;
  localparam logic [7:0] CH_COMMA  = 8'h6B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h25;
  localparam logic [7:0] CH_MINUS  = 8'h60;
  localparam logic [7:0] CH_PLUS   = 8'h4E;
  localparam logic [7:0] CH_DIG_LO = 8'hF0;
  localparam logic [7:0] CH_DIG_HI = 8'hF9;

  // longest number line in characters
  localparam logic [3:0] MAX_LINE = 4'd9;

  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned NUM_W   = 30;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd16370;

  // result queue sizing
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_ARRAY,
    PH_COUNT,
    PH_BULK,
    PH_LEN,
    PH_DATA,
    PH_CR,
    PH_LF
  } rsmj_phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } rsmj_status_e;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_STATUS = 1'b1
  } rsmj_kind_e;

  // one result beat
  typedef struct packed {
    rsmj_kind_e          kind;
    logic [7:0]          data;
    rsmj_status_e        status;
    logic [NUM_W-1:0]    count;
    logic                last;
  } rsmj_res_t;

  // results produced by one input beat, in order
  typedef struct packed {
    logic [1:0] num;
    rsmj_res_t  r0;
    rsmj_res_t  r1;
  } rsmj_push_t;

endpackage

`default_nettype wire

// ===== hdl/resp_set_members_joiner.sv =====
// top level: reply parser feeding the result queue
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata resp_byte, tlast end_of_response
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata byte/status/count, tuser kind, tlast
// cfg      in   cfg_we_i                     cfg_wdata_i output_limit
//
// one reply byte is taken per cycle while the queue has room; its results come out of a four-beat queue
// a byte gives at most two result beats; the first is offered the cycle after the byte if the queue was empty
// input stalls only while the queue holds more than two beats
// reset clears the parse state and the queue and loads output_limit with 16370
`default_nettype none

module resp_set_members_joiner (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rsmj_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // [7:0] resp_byte
  input  wire logic                         s_axis_tlast,  // end_of_response
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [39:0]                       m_axis_tdata,  // [7:0] out_byte, [9:8] status,
                                                           // [39:10] member_count
  output logic                              m_axis_tuser,  // out_kind
  output logic                              m_axis_tlast   // last
);
  import rsmj_pkg::*;

  logic       in_fire;
  logic       room;
  rsmj_push_t push;
  rsmj_res_t  res;

  assign s_axis_tready = room;
  assign in_fire       = s_axis_tvalid && room;

  // per-byte parse
  rsmj_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .push_o      (push)
  );

  // result beat queue
  rsmj_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .room_o    (room),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res)
  );

  // output beat packing
  assign m_axis_tdata = {res.count, res.status, res.data};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== hdl/rsmj_parser.sv =====
// reply parser: state registers and per-byte decode into result beats
`default_nettype none
`include "resp_set_members_joiner_assert.svh"

module rsmj_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rsmj_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  wire logic                         in_fire_i,
  input  wire logic [7:0]                   in_byte_i,
  input  wire logic                         in_last_i,
  output rsmj_pkg::rsmj_push_t              push_o
);
  import rsmj_pkg::*;

  // configuration and parse state
  logic [LIMIT_W-1:0] limit_q;
  rsmj_phase_e        phase_q, phase_d;
  logic [NUM_W-1:0]   accum_q, accum_d;
  logic [3:0]         lc_q, lc_d;
  logic               cr_q, cr_d;
  logic               neg_q, neg_d;
  logic               stopped_q, stopped_d;
  logic [NUM_W-1:0]   elems_q, elems_d;
  logic [NUM_W-1:0]   members_q, members_d;
  logic [NUM_W-1:0]   data_left_q, data_left_d;
  logic [LIMIT_W-1:0] pos_q, pos_d;
  logic               finished_q, finished_d;
  logic               fits_q, fits_d;
  logic               stop_q, stop_d;

  // decode results
  logic               active;
  logic               is_digit;
  logic               line_end;
  logic [3:0]         lc_eff;
  logic               stopped_eff;
  logic               comma_fit;
  logic               comma_full;
  logic [LIMIT_W-1:0] pos_c;
  logic [NUM_W:0]     span;
  logic               elem_fit;
  logic [NUM_W-1:0]   members_inc;
  logic [NUM_W-1:0]   accum_x10;
  logic               ev_byte;
  logic [7:0]         ev_byte_val;
  logic               ev_status;
  rsmj_status_e       ev_code;
  logic [NUM_W-1:0]   ev_count;
  logic               eor_bad;
  rsmj_res_t          byte_res, stat_res;

  assign active      = in_fire_i && !finished_q;
  assign is_digit    = (in_byte_i >= CH_DIG_LO) && (in_byte_i <= CH_DIG_HI);
  assign line_end    = cr_q && (in_byte_i == CH_LF);
  assign lc_eff      = lc_q + {3'b000, cr_q};
  assign stopped_eff = cr_q | stopped_q;
  assign members_inc = members_q + NUM_W'(1);
  assign accum_x10   = {accum_q[NUM_W-4:0], 3'b000} + {accum_q[NUM_W-2:0], 1'b0};

  // output room checks at the end of a length line
  assign comma_fit  = (members_q != '0) &&
                      (({1'b0, pos_q} + 17'd1) < {1'b0, limit_q});
  assign comma_full = (members_q != '0) && !comma_fit;
  assign pos_c      = pos_q + {{(LIMIT_W-1){1'b0}}, comma_fit};
  assign span       = {{(NUM_W+1-LIMIT_W){1'b0}}, pos_c} + {1'b0, accum_q};
  assign elem_fit   = !comma_full && (span < {{(NUM_W+1-LIMIT_W){1'b0}}, limit_q});

  // per-byte events
  always_comb begin
    ev_byte     = 1'b0;
    ev_byte_val = in_byte_i;
    ev_status   = 1'b0;
    ev_code     = ST_BAD;
    ev_count    = '0;
    if (active) begin
      case (phase_q)
        PH_ARRAY: begin
          ev_status = (in_byte_i != CH_STAR);
        end
        PH_BULK: begin
          ev_status = (in_byte_i != CH_DOLLAR);
        end
        PH_COUNT, PH_LEN: begin
          if (line_end) begin
            if (phase_q == PH_COUNT) begin
              if (neg_q || accum_q == '0) begin
                ev_status = 1'b1;
                ev_code   = ST_EMPTY;
              end
            end else if (neg_q && accum_q != '0) begin
              ev_status = 1'b1;
            end else if (comma_fit) begin
              ev_byte     = 1'b1;
              ev_byte_val = CH_COMMA;
            end
          end else if (cr_q && lc_q >= MAX_LINE) begin
            ev_status = 1'b1;
          end else if (in_byte_i != CH_CR && lc_eff >= MAX_LINE) begin
            ev_status = 1'b1;
          end
        end
        PH_DATA: begin
          ev_byte = fits_q;
        end
        PH_CR: begin
          ev_status = (in_byte_i != CH_CR);
        end
        PH_LF: begin
          if (in_byte_i != CH_LF) begin
            ev_status = 1'b1;
          end else if (stop_q || elems_q == NUM_W'(1)) begin
            ev_status = 1'b1;
            ev_count  = stop_q ? members_q : members_inc;
            ev_code   = (ev_count != '0) ? ST_OK : ST_EMPTY;
            if (ev_count == '0) begin
              ev_count = '0;
            end
          end
        end
        default: begin
          ev_status = 1'b1;
        end
      endcase
    end
  end

  assign eor_bad = in_fire_i && in_last_i && !finished_q && !ev_status;

  // result beats in model order: byte first, then status
  always_comb begin
    byte_res        = '0;
    byte_res.kind   = KIND_BYTE;
    byte_res.data   = ev_byte_val;
    stat_res        = '0;
    stat_res.kind   = KIND_STATUS;
    stat_res.status = ev_status ? ev_code : ST_BAD;
    stat_res.count  = (ev_status && ev_code == ST_OK) ? ev_count : '0;
    stat_res.last   = 1'b1;
    push_o          = '0;
    push_o.num      = {1'b0, ev_byte} + {1'b0, ev_status | eor_bad};
    push_o.r0       = ev_byte ? byte_res : stat_res;
    push_o.r1       = stat_res;
  end

  // next state
  always_comb begin
    phase_d     = phase_q;
    accum_d     = accum_q;
    lc_d        = lc_q;
    cr_d        = cr_q;
    neg_d       = neg_q;
    stopped_d   = stopped_q;
    elems_d     = elems_q;
    members_d   = members_q;
    data_left_d = data_left_q;
    pos_d       = pos_q;
    finished_d  = finished_q;
    fits_d      = fits_q;
    stop_d      = stop_q;
    if (in_fire_i && in_last_i) begin
      phase_d     = PH_ARRAY;
      accum_d     = '0;
      lc_d        = '0;
      cr_d        = 1'b0;
      neg_d       = 1'b0;
      stopped_d   = 1'b0;
      elems_d     = '0;
      members_d   = '0;
      data_left_d = '0;
      pos_d       = '0;
      finished_d  = 1'b0;
      fits_d      = 1'b0;
      stop_d      = 1'b0;
    end else if (active && ev_status) begin
      finished_d = 1'b1;
    end else if (active) begin
      case (phase_q)
        PH_ARRAY, PH_BULK: begin
          phase_d   = (phase_q == PH_ARRAY) ? PH_COUNT : PH_LEN;
          accum_d   = '0;
          lc_d      = '0;
          cr_d      = 1'b0;
          neg_d     = 1'b0;
          stopped_d = 1'b0;
        end
        PH_COUNT, PH_LEN: begin
          if (line_end) begin
            if (phase_q == PH_COUNT) begin
              elems_d = accum_q;
              phase_d = PH_BULK;
            end else begin
              data_left_d = accum_q;
              pos_d       = pos_c;
              fits_d      = elem_fit;
              stop_d      = !elem_fit;
              phase_d     = (accum_q != '0) ? PH_DATA : PH_CR;
            end
          end else begin
            // a lone cr counts as an ordinary line character
            cr_d      = 1'b0;
            stopped_d = stopped_eff;
            lc_d      = lc_eff;
            if (in_byte_i == CH_CR) begin
              cr_d = 1'b1;
            end else begin
              lc_d = lc_eff + 4'd1;
              if (lc_eff == '0 && in_byte_i == CH_MINUS) begin
                neg_d = 1'b1;
              end else if (lc_eff == '0 && in_byte_i == CH_PLUS) begin
                neg_d = neg_q;
              end else if (!stopped_eff && is_digit) begin
                accum_d = accum_x10 + {{(NUM_W-4){1'b0}}, in_byte_i[3:0]};
              end else begin
                stopped_d = 1'b1;
              end
            end
          end
        end
        PH_DATA: begin
          if (fits_q) begin
            pos_d = pos_q + LIMIT_W'(1);
          end
          data_left_d = data_left_q - NUM_W'(1);
          if (data_left_q == NUM_W'(1)) begin
            phase_d = PH_CR;
          end
        end
        PH_CR: begin
          phase_d = PH_LF;
        end
        PH_LF: begin
          members_d = members_inc;
          elems_d   = elems_q - NUM_W'(1);
          phase_d   = PH_BULK;
        end
        default: begin
          phase_d = PH_ARRAY;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      phase_q     <= PH_ARRAY;
      accum_q     <= '0;
      lc_q        <= '0;
      cr_q        <= 1'b0;
      neg_q       <= 1'b0;
      stopped_q   <= 1'b0;
      elems_q     <= '0;
      members_q   <= '0;
      data_left_q <= '0;
      pos_q       <= '0;
      finished_q  <= 1'b0;
      fits_q      <= 1'b0;
      stop_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      accum_q     <= accum_d;
      lc_q        <= lc_d;
      cr_q        <= cr_d;
      neg_q       <= neg_d;
      stopped_q   <= stopped_d;
      elems_q     <= elems_d;
      members_q   <= members_d;
      data_left_q <= data_left_d;
      pos_q       <= pos_d;
      finished_q  <= finished_d;
      fits_q      <= fits_d;
      stop_q      <= stop_d;
    end
  end

  // checks
  `RSMJ_ASSERT(a_pair_is_byte_then_bad, (push_o.num == 2'd2) |-> (push_o.r0.kind == KIND_BYTE && push_o.r1.kind == KIND_STATUS && push_o.r1.status == ST_BAD), "two results must be a byte then a malformed status")
  `RSMJ_ASSERT(a_quiet_after_outcome, (finished_q && !(in_fire_i && in_last_i)) |-> (push_o.num == 2'd0), "results after the outcome of a reply")
  `RSMJ_ASSERT_NEXT(a_rearm_after_last, (in_fire_i && in_last_i), (phase_q == PH_ARRAY && !finished_q && members_q == '0 && pos_q == '0), "parse state not rearmed after last beat")

endmodule

`default_nettype wire

// ===== hdl/rsmj_out_fifo.sv =====
// result queue: takes up to two beats per cycle while it has room, hands out one when the consumer is ready
`default_nettype none
`include "resp_set_members_joiner_assert.svh"

module rsmj_out_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rsmj_pkg::rsmj_push_t push_i,
  output logic                      room_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output rsmj_pkg::rsmj_res_t       m_res_o
);
  import rsmj_pkg::*;

  rsmj_res_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] wptr_nx;
  logic             pop;

  // room for a worst-case pair of beats
  assign room_o    = count_q <= CNT_W'(FIFO_DEPTH - 2);
  assign m_valid_o = count_q != '0;
  assign m_res_o   = mem_q[rptr_q];
  assign pop       = m_valid_o && m_ready_i;
  assign wptr_nx   = wptr_q + PTR_W'(1);

  // pointer and fill updates
  always_comb begin
    wptr_d  = wptr_q + push_i.num[PTR_W-1:0];
    rptr_d  = rptr_q + {{(PTR_W-1){1'b0}}, pop};
    count_d = count_q + {{(CNT_W-2){1'b0}}, push_i.num} - {{(CNT_W-1){1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wptr_nx] <= push_i.r1;
    end
  end

  // checks
  `RSMJ_ASSERT(a_fill_in_range, (count_q <= CNT_W'(FIFO_DEPTH)), "queue fill beyond depth")
  `RSMJ_ASSERT(a_push_needs_room, (push_i.num != 2'd0) |-> room_o, "beats pushed without room")
  `RSMJ_ASSERT_NEXT(a_valid_after_push, (push_i.num != 2'd0), m_valid_o, "queue empty after a push")

endmodule

`default_nettype wire
